>>> rtl/core/debounced_phase_sequencer_assert.svh
// ----------------------------------------------------------------------------
// debounced phase sequencer assertion macros
// implication checks on clk, switched off in synthesis
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_PHASE_SEQUENCER_ASSERT_SVH
`define DEBOUNCED_PHASE_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DPS_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define DPS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`else

`define DPS_ASSERT_IMPL(name, pre, post, msg)
`define DPS_ASSERT_NEXT(name, pre, post, msg)

`endif

`endif

>>> rtl/core/dps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_pkg
// types, register map and helpers for the debounced phase sequencer
// ----------------------------------------------------------------------------
package dps_pkg;

  localparam int CLOCK_BITS   = 17;
  localparam int MAX_EDGES    = 2;
  localparam int ELAPSED_BITS = 10;
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 4;
  localparam int NUM_REGS     = 8;
  localparam int TIME_BITS    = 17;
  localparam int COUNT_BITS   = 16;

  localparam logic [TIME_BITS-1:0] OUT_TIME_MAX = '1;
  localparam logic [CFG_BITS-1:0]  FINAL_MIN_MS = 16'd40000;

  typedef logic [CLOCK_BITS-1:0]   clk_ms_t;
  typedef logic [ELAPSED_BITS-1:0] elapsed_t;
  typedef logic [CFG_BITS-1:0]     cfg_word_t;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_FITTING    = 2'd1,
    PH_TRANSITION = 2'd2,
    PH_FINAL      = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_GOTO    = 2'd2,
    CMD_GO      = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    CAUSE_NONE    = 4'd0,
    CAUSE_RESTART = 4'd1,
    CAUSE_FORCED  = 4'd2,
    CAUSE_GO      = 4'd3,
    CAUSE_FACE    = 4'd4,
    CAUSE_ABSENT  = 4'd5,
    CAUSE_FIT     = 4'd6,
    CAUSE_SCENE   = 4'd7,
    CAUSE_TIMEOUT = 4'd8
  } cause_t;

  // register indexes
  localparam int REG_IDLE_MIN       = 0;
  localparam int REG_IDLE_FACE_HOLD = 1;
  localparam int REG_FIT_MIN        = 2;
  localparam int REG_FIT_MAX        = 3;
  localparam int REG_FIT_FIT_HOLD   = 4;
  localparam int REG_FIT_ABS_HOLD   = 5;
  localparam int REG_TRANS_MAX      = 6;
  localparam int REG_FINAL_ABS_HOLD = 7;

  localparam cfg_word_t CFG_RESET [NUM_REGS] = '{
    16'd8000, 16'd1500, 16'd2000, 16'd30000,
    16'd1500, 16'd2500, 16'd12000, 16'd8000
  };

  // saturating add of an elapsed step onto a clock or hold
  function automatic clk_ms_t sat_add(clk_ms_t a, elapsed_t dt);
    logic [CLOCK_BITS:0] sum;
    sum = {1'b0, a} + (CLOCK_BITS+1)'(dt);
    return sum[CLOCK_BITS] ? '1 : sum[CLOCK_BITS-1:0];
  endfunction

  function automatic phase_t edge_zero_target(phase_t p);
    phase_t t;
    case (p)
      PH_IDLE:       t = PH_FITTING;
      PH_FITTING:    t = PH_TRANSITION;
      PH_TRANSITION: t = PH_FINAL;
      default:       t = PH_IDLE;
    endcase
    return t;
  endfunction

endpackage

>>> rtl/core/debounced_phase_sequencer.sv
`timescale 1ns / 1ps
// Path: each transaction passes the input register, then the result register.
// Throughput: one transaction per cycle unless out_ready stalls; all edge, timeout and
// command logic is one combinational pass between input register and result register.
// Reset: synchronous, puts the sequencer in idle with clock and holds at zero,
// entry count at one, configuration at its default values and both stages empty.
// ----------------------------------------------------------------------------
// debounced_phase_sequencer
// four-phase sequencer with debounced edges, phase minimum, timeouts and commands
// ----------------------------------------------------------------------------
`include "debounced_phase_sequencer_assert.svh"

module debounced_phase_sequencer
  import dps_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              cmd,
  input  logic [1:0]              target_phase,
  input  logic [ELAPSED_BITS-1:0] elapsed_ms,
  input  logic                    face_detect,
  input  logic                    fit_locked,
  input  logic                    scene_end,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              phase,
  output logic                    entered,
  output logic [3:0]              cause,
  output logic [TIME_BITS-1:0]    phase_time_ms,
  output logic [COUNT_BITS-1:0]   entry_count
);

  cfg_word_t cfg_regs [NUM_REGS];

  // input register
  logic     inq_valid;
  cmd_t     inq_cmd;
  phase_t   inq_target;
  elapsed_t inq_dt;
  logic     inq_face;
  logic     inq_fit;
  logic     inq_done;

  // sequencer state
  phase_t                cur_phase;
  clk_ms_t               phase_clock;
  clk_ms_t               hold [MAX_EDGES];
  logic                  scene_flag;
  logic [COUNT_BITS-1:0] entries_seen;

  phase_t                phase_next;
  clk_ms_t               clock_next;
  clk_ms_t               hold_next [MAX_EDGES];
  logic                  scene_flag_next;
  logic [COUNT_BITS-1:0] entries_next;
  cause_t                cause_next;

  // per-phase edge description
  logic      lvl0, lvl1, two_edges, ungated0, fire0, fire1, timeout;
  cfg_word_t th0, th1, min_ms, max_ms;
  phase_t    tgt0, tgt1, timeout_to, enter_to;
  cause_t    cz0, cz1;
  logic      flag_tick, do_enter;
  clk_ms_t   clock_tick, hold0_tick, hold1_tick;
  logic [31:0] time_ext;

  logic accept, fire;

  assign accept   = in_valid && in_ready;
  assign fire     = inq_valid && (!out_valid || out_ready);
  assign in_ready = !inq_valid || fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_regs[i] <= CFG_RESET[i];
    end else if (cfg_we && cfg_index < CFG_IDX_BITS'(NUM_REGS)) begin
      cfg_regs[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (accept) begin
      inq_valid <= 1'b1;
    end else if (fire) begin
      inq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      inq_cmd    <= cmd_t'(cmd);
      inq_target <= phase_t'(target_phase);
      inq_dt     <= elapsed_ms;
      inq_face   <= face_detect;
      inq_fit    <= fit_locked;
      inq_done   <= scene_end;
    end
  end

  // edge table of the current phase
  always_comb begin
    lvl0       = 1'b0;
    lvl1       = 1'b0;
    two_edges  = 1'b0;
    ungated0   = 1'b0;
    th0        = '0;
    th1        = '0;
    min_ms     = '0;
    max_ms     = '0;
    tgt0       = PH_IDLE;
    tgt1       = PH_IDLE;
    timeout_to = PH_IDLE;
    cz0        = CAUSE_NONE;
    cz1        = CAUSE_NONE;
    flag_tick  = scene_flag | inq_done;
    case (cur_phase)
      PH_IDLE: begin
        lvl0   = inq_face;
        th0    = cfg_regs[REG_IDLE_FACE_HOLD];
        tgt0   = PH_FITTING;
        cz0    = CAUSE_FACE;
        min_ms = cfg_regs[REG_IDLE_MIN];
      end
      PH_FITTING: begin
        two_edges  = 1'b1;
        lvl0       = inq_fit;
        th0        = cfg_regs[REG_FIT_FIT_HOLD];
        tgt0       = PH_TRANSITION;
        cz0        = CAUSE_FIT;
        lvl1       = !inq_face;
        th1        = cfg_regs[REG_FIT_ABS_HOLD];
        tgt1       = PH_IDLE;
        cz1        = CAUSE_ABSENT;
        min_ms     = cfg_regs[REG_FIT_MIN];
        max_ms     = cfg_regs[REG_FIT_MAX];
        timeout_to = PH_IDLE;
      end
      PH_TRANSITION: begin
        // zero debounce, not held back by any minimum
        lvl0       = flag_tick;
        tgt0       = PH_FINAL;
        cz0        = CAUSE_SCENE;
        ungated0   = 1'b1;
        max_ms     = cfg_regs[REG_TRANS_MAX];
        timeout_to = PH_FINAL;
      end
      default: begin
        lvl0   = !inq_face;
        th0    = cfg_regs[REG_FINAL_ABS_HOLD];
        tgt0   = PH_IDLE;
        cz0    = CAUSE_ABSENT;
        min_ms = FINAL_MIN_MS;
      end
    endcase
  end

  assign clock_tick = sat_add(phase_clock, inq_dt);
  assign hold0_tick = lvl0 ? sat_add(hold[0], inq_dt) : '0;
  assign hold1_tick = lvl1 ? sat_add(hold[1], inq_dt) : '0;

  assign fire0   = lvl0 && hold0_tick >= CLOCK_BITS'(th0)
                   && (ungated0 || clock_tick >= CLOCK_BITS'(min_ms));
  assign fire1   = two_edges && !fire0 && lvl1 && hold1_tick >= CLOCK_BITS'(th1)
                   && clock_tick >= CLOCK_BITS'(min_ms);
  assign timeout = !fire0 && !fire1 && max_ms != '0
                   && clock_tick >= CLOCK_BITS'(max_ms);

  always_comb begin
    do_enter        = 1'b1;
    enter_to        = PH_IDLE;
    cause_next      = CAUSE_NONE;
    phase_next      = cur_phase;
    clock_next      = phase_clock;
    scene_flag_next = scene_flag;
    entries_next    = entries_seen;
    for (int i = 0; i < MAX_EDGES; i++) hold_next[i] = hold[i];
    case (inq_cmd)
      CMD_RESTART: begin
        enter_to   = PH_IDLE;
        cause_next = CAUSE_RESTART;
      end
      CMD_GOTO: begin
        enter_to   = inq_target;
        cause_next = CAUSE_FORCED;
      end
      CMD_GO: begin
        enter_to   = edge_zero_target(cur_phase);
        cause_next = CAUSE_GO;
      end
      default: begin
        clock_next      = clock_tick;
        scene_flag_next = flag_tick;
        hold_next[0]    = hold0_tick;
        if (two_edges) hold_next[1] = hold1_tick;
        if (fire0) begin
          enter_to   = tgt0;
          cause_next = cz0;
        end else if (fire1) begin
          enter_to   = tgt1;
          cause_next = cz1;
        end else if (timeout) begin
          enter_to   = timeout_to;
          cause_next = CAUSE_TIMEOUT;
        end else begin
          do_enter = 1'b0;
        end
      end
    endcase
    if (do_enter) begin
      phase_next      = enter_to;
      clock_next      = '0;
      scene_flag_next = 1'b0;
      entries_next    = entries_seen + 1'b1;
      for (int i = 0; i < MAX_EDGES; i++) hold_next[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_phase    <= PH_IDLE;
      phase_clock  <= '0;
      scene_flag   <= 1'b0;
      entries_seen <= COUNT_BITS'(1);
      for (int i = 0; i < MAX_EDGES; i++) hold[i] <= '0;
    end else if (fire) begin
      cur_phase    <= phase_next;
      phase_clock  <= clock_next;
      scene_flag   <= scene_flag_next;
      entries_seen <= entries_next;
      for (int i = 0; i < MAX_EDGES; i++) hold[i] <= hold_next[i];
    end
  end

  // result register
  assign time_ext = 32'(clock_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      phase         <= phase_next;
      entered       <= do_enter;
      cause         <= cause_next;
      phase_time_ms <= (time_ext > 32'(OUT_TIME_MAX)) ? OUT_TIME_MAX
                                                      : time_ext[TIME_BITS-1:0];
      entry_count   <= entries_next;
    end
  end

  `DPS_ASSERT_IMPL(a_entry_clears_clock, out_valid && entered, phase_time_ms == '0, "entry time")
  `DPS_ASSERT_IMPL(a_entered_matches_cause, out_valid, entered == (cause != CAUSE_NONE), "cause")
  `DPS_ASSERT_NEXT(a_fire_loads_result, fire, out_valid, "result lost after processing")
  `DPS_ASSERT_NEXT(a_count_holds, fire && !do_enter, entry_count == $past(entries_seen), "count")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the debounced phase sequencer. A short table of
// directed transactions comes first. Random tick and command traffic follows
// under several register settings. Every result is compared with a table value
// or with a phase calculation kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import dps_pkg::*;

  localparam int DT_MAX       = 2**ELAPSED_BITS - 1;
  localparam int IDX_MAX      = 2**CFG_IDX_BITS - 1;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_NS     = 1_000_000;

  typedef struct {
    cmd_t     cmd;
    phase_t   target;
    elapsed_t dt;
    bit       face;
    bit       fit;
    bit       done;
  } seq_item_t;

  typedef struct {
    phase_t                 phase;
    bit                     entered;
    cause_t                 cause;
    logic [TIME_BITS-1:0]   phase_time;
    logic [COUNT_BITS-1:0]  count;
  } seq_result_t;

  typedef struct {
    seq_item_t   item;
    bit          fixed;
    seq_result_t want;
  } table_row_t;

  typedef enum int {
    SET_SMALL,
    SET_ZERO,
    SET_FULL,
    SET_RANDOM,
    SET_MODERATE
  } reg_set_t;

  logic                    clk;
  logic                    rst           = 1'b1;
  logic                    cfg_we        = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index     = '0;
  logic [CFG_BITS-1:0]     cfg_data      = '0;
  logic                    in_valid      = 1'b0;
  logic                    in_ready;
  logic [1:0]              cmd           = '0;
  logic [1:0]              target_phase  = '0;
  logic [ELAPSED_BITS-1:0] elapsed_ms    = '0;
  logic                    face_detect   = 1'b0;
  logic                    fit_locked    = 1'b0;
  logic                    scene_end     = 1'b0;
  logic                    out_valid;
  logic                    out_ready     = 1'b0;
  logic [1:0]              phase;
  logic                    entered;
  logic [3:0]              cause;
  logic [TIME_BITS-1:0]    phase_time_ms;
  logic [COUNT_BITS-1:0]   entry_count;

  // sequencer state as the bench sees it
  cfg_word_t               seq_cfg [NUM_REGS];
  phase_t                  seq_phase;
  clk_ms_t                 seq_clock_ms;
  clk_ms_t                 seq_hold_ms [MAX_EDGES];
  bit                      seq_scene_seen;
  logic [COUNT_BITS-1:0]   seq_entries;

  seq_result_t             pending_phase_results [$];
  table_row_t              directed_rows [$];
  seq_result_t             no_fixed;
  int                      mismatch_count = 0;
  int                      src_calm       = 0;
  int                      sink_calm      = 0;
  int                      sink_wait      = 0;
  bit                      face_lvl       = 1'b0;
  bit                      fit_lvl        = 1'b0;

  debounced_phase_sequencer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .target_phase  (target_phase),
    .elapsed_ms    (elapsed_ms),
    .face_detect   (face_detect),
    .fit_locked    (fit_locked),
    .scene_end     (scene_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .phase         (phase),
    .entered       (entered),
    .cause         (cause),
    .phase_time_ms (phase_time_ms),
    .entry_count   (entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #LIMIT_NS;
    $display("tb: failure");
    $finish;
  end

  function automatic clk_ms_t clock_add(clk_ms_t a, elapsed_t dt);
    return (dt > ~a) ? '1 : a + dt;
  endfunction

  function automatic void enter_phase(phase_t p);
    int i;
    seq_phase      = p;
    seq_clock_ms   = '0;
    for (i = 0; i < MAX_EDGES; i++) seq_hold_ms[i] = '0;
    seq_scene_seen = 1'b0;
    seq_entries    = seq_entries + 1'b1;
  endfunction

  function automatic seq_result_t next_phase_result(seq_item_t it);
    seq_result_t r;
    cause_t      why;
    bit          lv     [MAX_EDGES];
    cfg_word_t   deb    [MAX_EDGES];
    phase_t      dest   [MAX_EDGES];
    cause_t      tag    [MAX_EDGES];
    bit          nogate [MAX_EDGES];
    int          n_edges;
    int          i;
    cfg_word_t   min_ms;
    cfg_word_t   max_ms;
    phase_t      expiry;
    bit          fired;
    why     = CAUSE_NONE;
    fired   = 1'b0;
    n_edges = 1;
    min_ms  = '0;
    max_ms  = '0;
    expiry  = PH_IDLE;
    for (i = 0; i < MAX_EDGES; i++) begin
      lv[i]     = 1'b0;
      deb[i]    = '0;
      dest[i]   = PH_IDLE;
      tag[i]    = CAUSE_NONE;
      nogate[i] = 1'b0;
    end
    // edge table of the current phase, edge 0 first
    case (seq_phase)
      PH_IDLE: begin
        lv[0]   = it.face;
        deb[0]  = seq_cfg[REG_IDLE_FACE_HOLD];
        dest[0] = PH_FITTING;
        tag[0]  = CAUSE_FACE;
        min_ms  = seq_cfg[REG_IDLE_MIN];
      end
      PH_FITTING: begin
        n_edges = 2;
        lv[0]   = it.fit;
        deb[0]  = seq_cfg[REG_FIT_FIT_HOLD];
        dest[0] = PH_TRANSITION;
        tag[0]  = CAUSE_FIT;
        lv[1]   = !it.face;
        deb[1]  = seq_cfg[REG_FIT_ABS_HOLD];
        dest[1] = PH_IDLE;
        tag[1]  = CAUSE_ABSENT;
        min_ms  = seq_cfg[REG_FIT_MIN];
        max_ms  = seq_cfg[REG_FIT_MAX];
        expiry  = PH_IDLE;
      end
      PH_TRANSITION: begin
        lv[0]     = seq_scene_seen || it.done;
        dest[0]   = PH_FINAL;
        tag[0]    = CAUSE_SCENE;
        nogate[0] = 1'b1;
        max_ms    = seq_cfg[REG_TRANS_MAX];
        expiry    = PH_FINAL;
      end
      default: begin
        lv[0]   = !it.face;
        deb[0]  = seq_cfg[REG_FINAL_ABS_HOLD];
        dest[0] = PH_IDLE;
        tag[0]  = CAUSE_ABSENT;
        min_ms  = FINAL_MIN_MS;
      end
    endcase
    case (it.cmd)
      CMD_RESTART: begin
        enter_phase(PH_IDLE);
        why = CAUSE_RESTART;
      end
      CMD_GOTO: begin
        enter_phase(it.target);
        why = CAUSE_FORCED;
      end
      CMD_GO: begin
        enter_phase(dest[0]);
        why = CAUSE_GO;
      end
      default: begin
        if (it.done) seq_scene_seen = 1'b1;
        seq_clock_ms = clock_add(seq_clock_ms, it.dt);
        // first edge to fire wins, later edges keep their hold untouched
        for (i = 0; i < n_edges && !fired; i++) begin
          seq_hold_ms[i] = lv[i] ? clock_add(seq_hold_ms[i], it.dt) : '0;
          if (lv[i] && seq_hold_ms[i] >= deb[i] && (nogate[i] || seq_clock_ms >= min_ms)) begin
            enter_phase(dest[i]);
            why   = tag[i];
            fired = 1'b1;
          end
        end
        if (!fired && max_ms != '0 && seq_clock_ms >= max_ms) begin
          enter_phase(expiry);
          why = CAUSE_TIMEOUT;
        end
      end
    endcase
    r.phase      = seq_phase;
    r.entered    = (why != CAUSE_NONE);
    r.cause      = why;
    r.phase_time = seq_clock_ms;
    r.count      = seq_entries;
    return r;
  endfunction

  // idle cycles before the next transaction, with occasional calm stretches
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 8);
  endfunction

  function automatic void add_row(cmd_t c, phase_t tgt, int dt, bit face, bit fit, bit done,
                                  bit fixed, phase_t ph, bit ent, cause_t why, int t, int cnt);
    table_row_t row;
    row.item.cmd        = c;
    row.item.target     = tgt;
    row.item.dt         = elapsed_t'(dt);
    row.item.face       = face;
    row.item.fit        = fit;
    row.item.done       = done;
    row.fixed           = fixed;
    row.want.phase      = ph;
    row.want.entered    = ent;
    row.want.cause      = why;
    row.want.phase_time = TIME_BITS'(t);
    row.want.count      = COUNT_BITS'(cnt);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // sensed levels persist between ticks so that debounce holds can build up
  function automatic seq_item_t draw_item(int cmd_one_in, int flip_one_in, int dt_lo,
                                          int dt_hi);
    seq_item_t it;
    bit        glitch;
    if ($urandom_range(1, flip_one_in) == 1) face_lvl = !face_lvl;
    if ($urandom_range(1, flip_one_in) == 1) fit_lvl = !fit_lvl;
    if (cmd_one_in != 0 && $urandom_range(1, cmd_one_in) == 1) begin
      it.cmd    = cmd_t'($urandom_range(CMD_RESTART, CMD_GO));
      it.target = phase_t'($urandom_range(0, 3));
      it.dt     = elapsed_t'($urandom);
      it.face   = 1'($urandom);
      it.fit    = 1'($urandom);
      it.done   = 1'($urandom);
    end else begin
      glitch    = ($urandom_range(0, 19) == 0);
      it.cmd    = CMD_TICK;
      it.target = phase_t'($urandom_range(0, 3));
      it.dt     = ($urandom_range(0, 3) == 0) ? elapsed_t'($urandom_range(0, DT_MAX))
                                              : elapsed_t'($urandom_range(dt_lo, dt_hi));
      it.face   = glitch ? 1'($urandom) : face_lvl;
      it.fit    = glitch ? 1'($urandom) : fit_lvl;
      it.done   = ($urandom_range(0, 9) == 0);
    end
    return it;
  endfunction

  task automatic send_item(seq_item_t it, bit fixed, seq_result_t want);
    int          gap;
    seq_result_t got;
    gap = draw_gap(src_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= it.cmd;
    target_phase  <= it.target;
    elapsed_ms    <= it.dt;
    face_detect   <= it.face;
    fit_locked    <= it.fit;
    scene_end     <= it.done;
    do @(posedge clk); while (!in_ready);
    got = next_phase_result(it);
    pending_phase_results.insert(pending_phase_results.size(), fixed ? want : got);
  endtask

  task automatic run_random(int n, int cmd_one_in, int flip_one_in, int dt_lo, int dt_hi);
    repeat (n) send_item(draw_item(cmd_one_in, flip_one_in, dt_lo, dt_hi), 1'b0, no_fixed);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_phase_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(int idx, cfg_word_t v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx[CFG_IDX_BITS-1:0];
    cfg_data  <= v;
    if (idx < NUM_REGS) seq_cfg[idx] = v;
  endtask

  task automatic load_settings(reg_set_t kind);
    cfg_word_t v;
    int        r;
    for (r = 0; r < NUM_REGS; r++) begin
      case (kind)
        SET_SMALL:    v = cfg_word_t'($urandom_range(0, 60));
        SET_ZERO:     v = '0;
        SET_FULL:     v = '1;
        SET_MODERATE: v = cfg_word_t'($urandom_range(0, 4000));
        default:      v = cfg_word_t'($urandom);
      endcase
      cfg_write(r, v);
    end
    // writes to unmapped indexes must leave the map alone
    if (kind == SET_RANDOM)
      repeat (2) cfg_write($urandom_range(NUM_REGS, IDX_MAX), cfg_word_t'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    seq_result_t want;
    int          gap;
    if (rst) begin
      out_ready <= 1'b0;
      sink_wait <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_phase_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: phase %0d cause %0d time %0d count %0d",
                     phase, cause, phase_time_ms, entry_count);
        end else begin
          want = pending_phase_results.pop_front();
          if (phase !== want.phase || entered !== want.entered || cause !== want.cause ||
              phase_time_ms !== want.phase_time || entry_count !== want.count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected phase %0d entered %0d cause %0d time %0d count %0d",
                       want.phase, want.entered, want.cause, want.phase_time, want.count,
                       " / got phase %0d entered %0d cause %0d time %0d count %0d",
                       phase, entered, cause, phase_time_ms, entry_count);
          end
        end
        gap = draw_gap(sink_calm);
        if (gap != 0) begin
          out_ready <= 1'b0;
          sink_wait <= gap;
        end
      end else if (!out_ready) begin
        if (sink_wait <= 1) out_ready <= 1'b1;
        sink_wait <= sink_wait - 1;
      end
    end
  end

  initial begin : stimulus
    int r;
    for (r = 0; r < NUM_REGS; r++) seq_cfg[r] = CFG_RESET[r];
    seq_phase      = PH_IDLE;
    seq_clock_ms   = '0;
    for (r = 0; r < MAX_EDGES; r++) seq_hold_ms[r] = '0;
    seq_scene_seen = 1'b0;
    seq_entries    = COUNT_BITS'(1);
    no_fixed.phase      = PH_IDLE;
    no_fixed.entered    = 1'b0;
    no_fixed.cause      = CAUSE_NONE;
    no_fixed.phase_time = '0;
    no_fixed.count      = '0;

    // reset values, commands with their ignored fields at the extremes
    add_row(CMD_TICK, PH_IDLE, 0, 0, 0, 0, 1, PH_IDLE, 0, CAUSE_NONE, 0, 1);
    add_row(CMD_RESTART, PH_FINAL, DT_MAX, 1, 1, 1, 1, PH_IDLE, 1, CAUSE_RESTART, 0, 2);
    add_row(CMD_GOTO, PH_FINAL, DT_MAX, 1, 1, 1, 1, PH_FINAL, 1, CAUSE_FORCED, 0, 3);
    add_row(CMD_GO, PH_TRANSITION, 0, 0, 0, 1, 1, PH_IDLE, 1, CAUSE_GO, 0, 4);
    add_row(CMD_GOTO, PH_FITTING, 0, 0, 0, 0, 1, PH_FITTING, 1, CAUSE_FORCED, 0, 5);
    // scene pulse on a command is not latched
    add_row(CMD_GO, PH_IDLE, DT_MAX, 0, 1, 1, 1, PH_TRANSITION, 1, CAUSE_GO, 0, 6);
    add_row(CMD_TICK, PH_IDLE, 5, 1, 0, 0, 1, PH_TRANSITION, 0, CAUSE_NONE, 5, 6);
    // scene edge has no minimum and no debounce
    add_row(CMD_TICK, PH_IDLE, DT_MAX, 1, 1, 1, 1, PH_FINAL, 1, CAUSE_SCENE, 0, 7);
    add_row(CMD_TICK, PH_IDLE, DT_MAX, 0, 0, 0, 1, PH_FINAL, 0, CAUSE_NONE, DT_MAX, 7);
    add_row(CMD_GOTO, PH_IDLE, 0, 1, 0, 1, 1, PH_IDLE, 1, CAUSE_FORCED, 0, 8);
    // face held through the idle minimum
    repeat (8) add_row(CMD_TICK, PH_IDLE, DT_MAX, 1, 0, 0, 0, PH_IDLE, 0, CAUSE_NONE, 0, 0);
    // fit edge once the fitting minimum is reached
    repeat (2) add_row(CMD_TICK, PH_IDLE, DT_MAX, 1, 1, 0, 0, PH_IDLE, 0, CAUSE_NONE, 0, 0);
    add_row(CMD_GOTO, PH_FITTING, 0, 0, 0, 0, 0, PH_IDLE, 0, CAUSE_NONE, 0, 0);
    // face absent, debounced back to idle
    repeat (3) add_row(CMD_TICK, PH_IDLE, DT_MAX, 0, 0, 0, 0, PH_IDLE, 0, CAUSE_NONE, 0, 0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k])
      send_item(directed_rows[k].item, directed_rows[k].fixed, directed_rows[k].want);
    run_random(250, 12, 8, 0, DT_MAX);

    drain();
    load_settings(SET_SMALL);
    run_random(250, 16, 6, 0, 40);

    drain();
    load_settings(SET_ZERO);
    run_random(200, 10, 4, 0, 15);

    // long dwell with no commands so the phase clock saturates
    drain();
    load_settings(SET_FULL);
    face_lvl = 1'b0;
    run_random(300, 0, 200, 700, DT_MAX);

    drain();
    load_settings(SET_RANDOM);
    run_random(250, 20, 10, 0, DT_MAX);

    drain();
    load_settings(SET_MODERATE);
    run_random(280, 25, 10, 0, 600);

    drain();
    // two-stage pipe, allow a few cycles for any stray result
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_phase_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/dps_pkg.sv
rtl/core/debounced_phase_sequencer.sv
tb/tb_top.sv
